// File: hw/rtl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the timer table checkers.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ptt_pkg.sv
//------------------------------------------------------------------------------
// ptt_pkg
// Operation codes, field layout and default sizes of the periodic timer table.
//------------------------------------------------------------------------------
package ptt_pkg;

  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_KILL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  localparam int ID_W      = 4;
  localparam int IN_TIME_W = 32;

  // input beat: timer_id, period, now_time from bit 0 up
  localparam int ID_LSB     = 0;
  localparam int PERIOD_LSB = ID_LSB + ID_W;
  localparam int NOW_LSB    = PERIOD_LSB + IN_TIME_W;
  localparam int S_TDATA_W  = ((NOW_LSB + IN_TIME_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((ID_W + 7) / 8) * 8;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DEF_TIME_BITS   = 32;

endpackage

// File: hw/rtl/periodic_timer_table.sv
//------------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers with set, kill, clear and a scanning tick.
//------------------------------------------------------------------------------
// Set, kill and clear beats do not hold the input. A tick walks the table one
// slot per cycle, unless the output side stalls the scan, through the
// period/stamp RAM (read one slot while the slot read before it is compared
// and restamped), and holds the input until the final fired id has been
// loaded for output. Fired ids leave in ascending order, tlast marks the
// final one of the tick; a tick on which nothing fires gives no beat. Armed
// flags live in flops and clear at once on reset or clear.
//------------------------------------------------------------------------------
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // timer_id[3:0], period[35:4], now_time[67:36]
  input  logic [FUNC_W-1:0]    s_tuser,  // func[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // fired_id[3:0]
  output logic                 m_tlast   // last_fired
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int RAM_W = 2 * TIME_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]             state;
  logic [TIMER_SLOTS-1:0] armed;
  logic [TIME_BITS-1:0]   now_reg;
  logic [CNT_W-1:0]       rd_idx;
  logic                   ev_valid;
  logic [IDX_W-1:0]       ev_idx;
  logic                   pend_valid;
  logic [ID_W-1:0]        pend_id;
  logic [ID_W-1:0]        out_id;

  logic                   accept;
  logic [ID_W-1:0]        in_id;
  logic [IDX_W+ID_W-1:0]  in_id_ext;
  logic [IDX_W-1:0]       id_idx;
  logic                   id_ok;
  logic [TIME_BITS+IN_TIME_W-1:0] period_ext;
  logic [TIME_BITS+IN_TIME_W-1:0] now_ext;
  logic [TIME_BITS-1:0]   in_period;
  logic [TIME_BITS-1:0]   in_now;
  logic [IDX_W+ID_W-1:0]  ev_idx_ext;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [RAM_W-1:0]       ram_rdata;
  logic [TIME_BITS-1:0]   rd_period;
  logic [TIME_BITS-1:0]   rd_stamp;
  logic [TIME_BITS-1:0]   elapsed;

  logic                   ev_fire;
  logic                   out_free;
  logic                   stall;
  logic                   scan_go;
  logic                   more_reads;
  logic                   out_load;
  logic                   out_last;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign in_id      = s_tdata[ID_LSB +: ID_W];
  assign in_id_ext  = {{IDX_W{1'b0}}, in_id};
  assign id_idx     = in_id_ext[IDX_W-1:0];
  assign id_ok      = ({1'b0, in_id_ext} < (IDX_W + ID_W + 1)'(TIMER_SLOTS));
  assign period_ext = {{TIME_BITS{1'b0}}, s_tdata[PERIOD_LSB +: IN_TIME_W]};
  assign now_ext    = {{TIME_BITS{1'b0}}, s_tdata[NOW_LSB +: IN_TIME_W]};
  assign in_period  = period_ext[TIME_BITS-1:0];
  assign in_now     = now_ext[TIME_BITS-1:0];
  assign ev_idx_ext = {{ID_W{1'b0}}, ev_idx};

  assign rd_period = ram_rdata[RAM_W-1:TIME_BITS];
  assign rd_stamp  = ram_rdata[TIME_BITS-1:0];
  assign elapsed   = now_reg - rd_stamp;

  assign ev_fire    = ev_valid && armed[ev_idx] && (elapsed > rd_period);
  assign out_free   = !m_tvalid || m_tready;
  // hold the scan when a second fire would need the output before it drains
  assign stall      = ev_fire && pend_valid && !out_free;
  assign scan_go    = (state == ST_SCAN) && !stall;
  assign more_reads = (rd_idx < CNT_W'(TIMER_SLOTS));

  // a later fire proves the held id is not the last one
  assign out_load = (scan_go && ev_fire && pend_valid) ||
                    ((state == ST_FLUSH) && out_free);
  assign out_last = (state == ST_FLUSH);

  always_comb begin
    if (state == ST_IDLE) begin
      ram_we    = accept && (s_tuser == FUNC_SET) && id_ok;
      ram_waddr = id_idx;
      ram_wdata = {in_period, in_now};
      ram_re    = accept && (s_tuser == FUNC_TICK);
      ram_raddr = '0;
    end else begin
      ram_we    = scan_go && ev_fire;
      ram_waddr = ev_idx;
      ram_wdata = {rd_period, now_reg};
      ram_re    = scan_go && more_reads;
      ram_raddr = rd_idx[IDX_W-1:0];
    end
  end

  ptt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      armed      <= '0;
      rd_idx     <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        out_id   <= pend_id;
        m_tlast  <= out_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_tuser)
              FUNC_SET: begin
                if (id_ok) begin
                  armed[id_idx] <= 1'b1;
                end
              end
              FUNC_KILL: begin
                if (id_ok) begin
                  armed[id_idx] <= 1'b0;
                end
              end
              FUNC_TICK: begin
                now_reg  <= in_now;
                rd_idx   <= CNT_W'(1);
                ev_valid <= 1'b1;
                ev_idx   <= '0;
                state    <= ST_SCAN;
              end
              FUNC_CLEAR: begin
                armed <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (ev_fire) begin
              pend_valid <= 1'b1;
              pend_id    <= ev_idx_ext[ID_W-1:0];
            end
            if (more_reads) begin
              ev_valid <= 1'b1;
              ev_idx   <= rd_idx[IDX_W-1:0];
              rd_idx   <= rd_idx + CNT_W'(1);
            end else begin
              ev_valid <= 1'b0;
              if (!ev_valid) begin
                state <= pend_valid ? ST_FLUSH : ST_IDLE;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(M_TDATA_W - ID_W){1'b0}}, out_id};

endmodule

// File: hw/rtl/ptt_ram.sv
//------------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
//------------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ptt_checker.sv
//------------------------------------------------------------------------------
// ptt_checker
// Port-level assertions for the periodic timer table, bound to the top level.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module ptt_checker
  import ptt_pkg::*;
#(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [FUNC_W-1:0]    s_tuser,  // func[1:0]
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,  // fired_id[3:0]
  input logic                 m_tlast
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_tvalid)
  `ASSERT_NEXT(a_tick_busy, clk, rst, s_tvalid && s_tready && (s_tuser == FUNC_TICK), !s_tready)
  `ASSERT_IMPLIES(a_id_range, clk, rst, m_tvalid, m_tdata[ID_W-1:0] < TIMER_SLOTS)

endmodule

bind periodic_timer_table ptt_checker #(.TIMER_SLOTS(TIMER_SLOTS)) u_ptt_checker (.*);
